### rtl/core/rv32im_instruction_decoder_unit_assert.svh
// assertion macros for the rv32im instruction decoder
// no dependencies; included by modules that carry assertions
`ifndef RV32IM_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`define RV32IM_INSTRUCTION_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RVID_ASSERT_HOLDS(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rvid assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RVID_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rvid assertion failed");

`endif

### rtl/core/rvid_pkg.sv
// shared types and codes for the rv32im instruction decoder
// no dependencies; used by rvid_decode and the top level
package rvid_pkg;

    // stream widths
    localparam int unsigned TDATA_IN_W  = 64;
    localparam int unsigned TDATA_OUT_W = 96;
    localparam int unsigned TDATA_PAD_W = 7;

    // major opcode, instruction bits 6:2
    typedef enum logic [4:0] {
        OPC_LOAD   = 5'h00,
        OPC_FENCE  = 5'h03,
        OPC_OPIMM  = 5'h04,
        OPC_AUIPC  = 5'h05,
        OPC_STORE  = 5'h08,
        OPC_OP     = 5'h0C,
        OPC_LUI    = 5'h0D,
        OPC_BRANCH = 5'h18,
        OPC_JALR   = 5'h19,
        OPC_JAL    = 5'h1B,
        OPC_SYSTEM = 5'h1C
    } opc_t;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;

    // funct3 codes
    localparam logic [2:0] F3_JALR  = 3'd0;
    localparam logic [2:0] F3_FENCE = 3'd0;
    localparam logic [2:0] F3_BEQ   = 3'd0;
    localparam logic [2:0] F3_BNE   = 3'd1;
    localparam logic [2:0] F3_BLT   = 3'd4;
    localparam logic [2:0] F3_BGE   = 3'd5;
    localparam logic [2:0] F3_BLTU  = 3'd6;
    localparam logic [2:0] F3_BGEU  = 3'd7;
    localparam logic [2:0] F3_LB    = 3'd0;
    localparam logic [2:0] F3_LH    = 3'd1;
    localparam logic [2:0] F3_LW    = 3'd2;
    localparam logic [2:0] F3_LBU   = 3'd4;
    localparam logic [2:0] F3_LHU   = 3'd5;
    localparam logic [2:0] F3_SB    = 3'd0;
    localparam logic [2:0] F3_SH    = 3'd1;
    localparam logic [2:0] F3_SW    = 3'd2;
    localparam logic [2:0] F3_ADD   = 3'd0;
    localparam logic [2:0] F3_SLL   = 3'd1;
    localparam logic [2:0] F3_SLT   = 3'd2;
    localparam logic [2:0] F3_SLTU  = 3'd3;
    localparam logic [2:0] F3_XOR   = 3'd4;
    localparam logic [2:0] F3_SRL   = 3'd5;
    localparam logic [2:0] F3_OR    = 3'd6;
    localparam logic [2:0] F3_AND   = 3'd7;
    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    // format classes
    localparam logic [3:0] FMT_R      = 4'd0;
    localparam logic [3:0] FMT_I_ALU  = 4'd1;
    localparam logic [3:0] FMT_STORE  = 4'd2;
    localparam logic [3:0] FMT_LOAD   = 4'd3;
    localparam logic [3:0] FMT_BRANCH = 4'd4;
    localparam logic [3:0] FMT_UPPER  = 4'd5;
    localparam logic [3:0] FMT_JAL    = 4'd6;
    localparam logic [3:0] FMT_JALR   = 4'd7;
    localparam logic [3:0] FMT_FENCE  = 4'd8;
    localparam logic [3:0] FMT_SYSTEM = 4'd9;

    // dense mnemonic numbers
    localparam logic [5:0] MN_LUI    = 6'd0;
    localparam logic [5:0] MN_AUIPC  = 6'd1;
    localparam logic [5:0] MN_JAL    = 6'd2;
    localparam logic [5:0] MN_JALR   = 6'd3;
    localparam logic [5:0] MN_BEQ    = 6'd4;
    localparam logic [5:0] MN_BNE    = 6'd5;
    localparam logic [5:0] MN_BLT    = 6'd6;
    localparam logic [5:0] MN_BGE    = 6'd7;
    localparam logic [5:0] MN_BLTU   = 6'd8;
    localparam logic [5:0] MN_BGEU   = 6'd9;
    localparam logic [5:0] MN_LB     = 6'd10;
    localparam logic [5:0] MN_LH     = 6'd11;
    localparam logic [5:0] MN_LW     = 6'd12;
    localparam logic [5:0] MN_LBU    = 6'd13;
    localparam logic [5:0] MN_LHU    = 6'd14;
    localparam logic [5:0] MN_SB     = 6'd15;
    localparam logic [5:0] MN_SH     = 6'd16;
    localparam logic [5:0] MN_SW     = 6'd17;
    localparam logic [5:0] MN_ADDI   = 6'd18;
    localparam logic [5:0] MN_SLTI   = 6'd19;
    localparam logic [5:0] MN_SLTIU  = 6'd20;
    localparam logic [5:0] MN_XORI   = 6'd21;
    localparam logic [5:0] MN_ORI    = 6'd22;
    localparam logic [5:0] MN_ANDI   = 6'd23;
    localparam logic [5:0] MN_SLLI   = 6'd24;
    localparam logic [5:0] MN_SRLI   = 6'd25;
    localparam logic [5:0] MN_SRAI   = 6'd26;
    localparam logic [5:0] MN_ADD    = 6'd27;
    localparam logic [5:0] MN_SUB    = 6'd28;
    localparam logic [5:0] MN_SLL    = 6'd29;
    localparam logic [5:0] MN_SLT    = 6'd30;
    localparam logic [5:0] MN_SLTU   = 6'd31;
    localparam logic [5:0] MN_XOR    = 6'd32;
    localparam logic [5:0] MN_SRL    = 6'd33;
    localparam logic [5:0] MN_SRA    = 6'd34;
    localparam logic [5:0] MN_OR     = 6'd35;
    localparam logic [5:0] MN_AND    = 6'd36;
    localparam logic [5:0] MN_MUL    = 6'd37;
    localparam logic [5:0] MN_MULH   = 6'd38;
    localparam logic [5:0] MN_MULHSU = 6'd39;
    localparam logic [5:0] MN_MULHU  = 6'd40;
    localparam logic [5:0] MN_DIV    = 6'd41;
    localparam logic [5:0] MN_DIVU   = 6'd42;
    localparam logic [5:0] MN_REM    = 6'd43;
    localparam logic [5:0] MN_REMU   = 6'd44;
    localparam logic [5:0] MN_FENCE  = 6'd45;
    localparam logic [5:0] MN_ECALL  = 6'd46;
    localparam logic [5:0] MN_EBREAK = 6'd47;

    // one decoded result word
    typedef struct packed {
        logic               valid_res;
        logic [3:0]         format;
        logic [5:0]         mnemonic;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [31:0]        jump_target;
    } decode_res_t;

endpackage

### rtl/core/rvid_decode.sv
// combinational rv32im decode of one instruction word and its address
// depends on rvid_pkg
module rvid_decode (
    input  logic [31:0]          instr_word,
    input  logic [31:0]          instr_addr,
    output rvid_pkg::decode_res_t res
);

    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic        is_32bit;
    logic        known;
    logic        has_target;
    logic [3:0]  fmt;
    logic [5:0]  mn;
    logic [4:0]  d;
    logic [4:0]  s1;
    logic [4:0]  s2;
    logic [31:0] imm;
    logic [31:0] tgt;

    // field extraction
    assign f3  = instr_word[14:12];
    assign f7  = instr_word[31:25];
    assign rd  = instr_word[11:7];
    assign rs1 = instr_word[19:15];
    assign rs2 = instr_word[24:20];

    // immediates per encoding format
    assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
    assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                    instr_word[20], instr_word[30:21], 1'b0};
    assign imm_u = {instr_word[31:12], 12'b0};

    // compressed and 48-bit-or-longer encodings are rejected
    assign is_32bit = (instr_word[1:0] == 2'b11) && (instr_word[4:2] != 3'b111);

    // opcode and funct decode
    always_comb begin
        known      = 1'b0;
        has_target = 1'b0;
        fmt        = rvid_pkg::FMT_R;
        mn         = rvid_pkg::MN_LUI;
        d          = 5'd0;
        s1         = 5'd0;
        s2         = 5'd0;
        imm        = 32'd0;
        unique case (rvid_pkg::opc_t'(instr_word[6:2]))
            rvid_pkg::OPC_LUI: begin
                known = 1'b1; fmt = rvid_pkg::FMT_UPPER; mn = rvid_pkg::MN_LUI;
                d = rd; imm = imm_u;
            end
            rvid_pkg::OPC_AUIPC: begin
                known = 1'b1; fmt = rvid_pkg::FMT_UPPER; mn = rvid_pkg::MN_AUIPC;
                d = rd; imm = imm_u;
            end
            rvid_pkg::OPC_JAL: begin
                known = 1'b1; has_target = 1'b1;
                fmt = rvid_pkg::FMT_JAL; mn = rvid_pkg::MN_JAL;
                d = rd; imm = imm_j;
            end
            rvid_pkg::OPC_JALR: begin
                known = (f3 == rvid_pkg::F3_JALR);
                fmt = rvid_pkg::FMT_JALR; mn = rvid_pkg::MN_JALR;
                d = rd; s1 = rs1; imm = imm_i;
            end
            rvid_pkg::OPC_BRANCH: begin
                known = 1'b1; has_target = 1'b1;
                fmt = rvid_pkg::FMT_BRANCH; s1 = rs1; s2 = rs2; imm = imm_b;
                unique case (f3)
                    rvid_pkg::F3_BEQ:  mn = rvid_pkg::MN_BEQ;
                    rvid_pkg::F3_BNE:  mn = rvid_pkg::MN_BNE;
                    rvid_pkg::F3_BLT:  mn = rvid_pkg::MN_BLT;
                    rvid_pkg::F3_BGE:  mn = rvid_pkg::MN_BGE;
                    rvid_pkg::F3_BLTU: mn = rvid_pkg::MN_BLTU;
                    rvid_pkg::F3_BGEU: mn = rvid_pkg::MN_BGEU;
                    default:           known = 1'b0;
                endcase
            end
            rvid_pkg::OPC_LOAD: begin
                known = 1'b1;
                fmt = rvid_pkg::FMT_LOAD; d = rd; s1 = rs1; imm = imm_i;
                unique case (f3)
                    rvid_pkg::F3_LB:  mn = rvid_pkg::MN_LB;
                    rvid_pkg::F3_LH:  mn = rvid_pkg::MN_LH;
                    rvid_pkg::F3_LW:  mn = rvid_pkg::MN_LW;
                    rvid_pkg::F3_LBU: mn = rvid_pkg::MN_LBU;
                    rvid_pkg::F3_LHU: mn = rvid_pkg::MN_LHU;
                    default:          known = 1'b0;
                endcase
            end
            rvid_pkg::OPC_STORE: begin
                known = 1'b1;
                fmt = rvid_pkg::FMT_STORE; s1 = rs1; s2 = rs2; imm = imm_s;
                unique case (f3)
                    rvid_pkg::F3_SB: mn = rvid_pkg::MN_SB;
                    rvid_pkg::F3_SH: mn = rvid_pkg::MN_SH;
                    rvid_pkg::F3_SW: mn = rvid_pkg::MN_SW;
                    default:         known = 1'b0;
                endcase
            end
            rvid_pkg::OPC_OPIMM: begin
                known = 1'b1;
                fmt = rvid_pkg::FMT_I_ALU; d = rd; s1 = rs1; imm = imm_i;
                unique case (f3)
                    rvid_pkg::F3_ADD:  mn = rvid_pkg::MN_ADDI;
                    rvid_pkg::F3_SLT:  mn = rvid_pkg::MN_SLTI;
                    rvid_pkg::F3_SLTU: mn = rvid_pkg::MN_SLTIU;
                    rvid_pkg::F3_XOR:  mn = rvid_pkg::MN_XORI;
                    rvid_pkg::F3_OR:   mn = rvid_pkg::MN_ORI;
                    rvid_pkg::F3_AND:  mn = rvid_pkg::MN_ANDI;
                    // shift-immediates carry only the 5-bit shamt
                    rvid_pkg::F3_SLL: begin
                        mn = rvid_pkg::MN_SLLI; imm = {27'd0, rs2};
                        known = (f7 == rvid_pkg::F7_BASE);
                    end
                    rvid_pkg::F3_SRL: begin
                        imm = {27'd0, rs2};
                        mn  = (f7 == rvid_pkg::F7_ALT) ? rvid_pkg::MN_SRAI
                                                       : rvid_pkg::MN_SRLI;
                        known = (f7 == rvid_pkg::F7_ALT) || (f7 == rvid_pkg::F7_BASE);
                    end
                    default: known = 1'b0;
                endcase
            end
            rvid_pkg::OPC_OP: begin
                known = 1'b1;
                fmt = rvid_pkg::FMT_R; d = rd; s1 = rs1; s2 = rs2;
                if (f7 == rvid_pkg::F7_BASE) begin
                    unique case (f3)
                        rvid_pkg::F3_ADD:  mn = rvid_pkg::MN_ADD;
                        rvid_pkg::F3_SLL:  mn = rvid_pkg::MN_SLL;
                        rvid_pkg::F3_SLT:  mn = rvid_pkg::MN_SLT;
                        rvid_pkg::F3_SLTU: mn = rvid_pkg::MN_SLTU;
                        rvid_pkg::F3_XOR:  mn = rvid_pkg::MN_XOR;
                        rvid_pkg::F3_SRL:  mn = rvid_pkg::MN_SRL;
                        rvid_pkg::F3_OR:   mn = rvid_pkg::MN_OR;
                        rvid_pkg::F3_AND:  mn = rvid_pkg::MN_AND;
                        default:           known = 1'b0;
                    endcase
                end else if (f7 == rvid_pkg::F7_MUL) begin
                    unique case (f3)
                        rvid_pkg::F3_MUL:    mn = rvid_pkg::MN_MUL;
                        rvid_pkg::F3_MULH:   mn = rvid_pkg::MN_MULH;
                        rvid_pkg::F3_MULHSU: mn = rvid_pkg::MN_MULHSU;
                        rvid_pkg::F3_MULHU:  mn = rvid_pkg::MN_MULHU;
                        rvid_pkg::F3_DIV:    mn = rvid_pkg::MN_DIV;
                        rvid_pkg::F3_DIVU:   mn = rvid_pkg::MN_DIVU;
                        rvid_pkg::F3_REM:    mn = rvid_pkg::MN_REM;
                        rvid_pkg::F3_REMU:   mn = rvid_pkg::MN_REMU;
                        default:             known = 1'b0;
                    endcase
                end else if (f7 == rvid_pkg::F7_ALT) begin
                    unique case (f3)
                        rvid_pkg::F3_ADD: mn = rvid_pkg::MN_SUB;
                        rvid_pkg::F3_SRL: mn = rvid_pkg::MN_SRA;
                        default:          known = 1'b0;
                    endcase
                end else begin
                    known = 1'b0;
                end
            end
            rvid_pkg::OPC_FENCE: begin
                // pred and succ sets ride in the source fields
                known = (f3 == rvid_pkg::F3_FENCE);
                fmt = rvid_pkg::FMT_FENCE; mn = rvid_pkg::MN_FENCE;
                s1 = {1'b0, instr_word[27:24]};
                s2 = {1'b0, instr_word[23:20]};
            end
            rvid_pkg::OPC_SYSTEM: begin
                // only bit 20 separates ebreak from ecall
                known = 1'b1; fmt = rvid_pkg::FMT_SYSTEM;
                mn = instr_word[20] ? rvid_pkg::MN_EBREAK : rvid_pkg::MN_ECALL;
            end
            default: known = 1'b0;
        endcase
    end

    // branch and jal target, wraps at 32 bits
    assign tgt = has_target ? (instr_addr + imm) : 32'd0;

    // invalid words give an all-zero result
    always_comb begin
        res = '0;
        if (is_32bit && known) begin
            res.valid_res   = 1'b1;
            res.format      = fmt;
            res.mnemonic    = mn;
            res.dest_reg    = d;
            res.src1_reg    = s1;
            res.src2_reg    = s2;
            res.immediate   = imm;
            res.jump_target = tgt;
        end
    end

endmodule

### rtl/core/rv32im_instruction_decoder_unit.sv
// rv32im instruction decoder, stream in and stream out
// depends on rvid_pkg, rvid_decode and rv32im_instruction_decoder_unit_assert.svh
// an accepted input word passes the input register and then the result register before its result is on m_tdata
// throughput: one word per cycle while m_tready is not held low; input register, decode logic, result register
// both stages advance whenever the result register is free or being taken; the input register also loads while empty
// reset: synchronous, active low, clears only the two stage valid flags
`include "rv32im_instruction_decoder_unit_assert.svh"

module rv32im_instruction_decoder_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // instr_word [31:0], instr_addr [63:32]
    input  logic [rvid_pkg::TDATA_IN_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // format [3:0], mnemonic [9:4], dest_reg [14:10], src1_reg [19:15],
    // src2_reg [24:20], immediate [56:25], jump_target [88:57], zero [95:89]
    output logic [rvid_pkg::TDATA_OUT_W-1:0]   m_tdata,
    // valid_res [0]
    output logic [0:0]                         m_tuser
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [31:0]           in_word_reg;
    logic [31:0]           in_addr_reg;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    rvid_pkg::decode_res_t res_reg;
    rvid_pkg::decode_res_t res_next;
    logic                  res_adv;
    logic                  in_load;

    // stage advance: result register is empty or its word is being taken
    assign res_adv  = !res_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || res_adv;
    assign in_load  = s_tvalid && s_tready;

    // next valid flags
    always_comb begin
        in_valid_next  = in_valid_reg;
        res_valid_next = res_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (res_adv) begin
            res_valid_next = in_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg <= s_tdata[31:0];
            in_addr_reg <= s_tdata[63:32];
        end
    end

    // decode logic
    rvid_decode u_decode (
        .instr_word (in_word_reg),
        .instr_addr (in_addr_reg),
        .res        (res_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (res_adv && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    // output packing
    assign m_tvalid = res_valid_reg;
    assign m_tuser  = res_reg.valid_res;
    assign m_tdata  = {{rvid_pkg::TDATA_PAD_W{1'b0}},
                       res_reg.jump_target,
                       res_reg.immediate,
                       res_reg.src2_reg,
                       res_reg.src1_reg,
                       res_reg.dest_reg,
                       res_reg.mnemonic,
                       res_reg.format};

    // checks
    `RVID_ASSERT_HOLDS(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0)
    `RVID_ASSERT_HOLDS(a_mn_range, aclk, aresetn, m_tvalid, m_tdata[9:4] <= rvid_pkg::MN_EBREAK)
    `RVID_ASSERT_HOLDS(a_tgt_zero, aclk, aresetn, m_tvalid && (m_tdata[3:0] != rvid_pkg::FMT_BRANCH) && (m_tdata[3:0] != rvid_pkg::FMT_JAL), m_tdata[88:57] == 32'd0)
    `RVID_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !res_adv, in_valid_reg && $stable(in_word_reg) && $stable(in_addr_reg))

endmodule
